[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH and get
// empty bodies, so nothing here reaches the netlist.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked implication or plain property, checked outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

[hw/rtl/tsgd_pkg.sv]
`timescale 1ns / 1ps

package tsgd_pkg;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] CMD_ADD_ONE  = 2'd0;
   localparam logic [1:0] CMD_ADD_TWO  = 2'd1;
   localparam logic [1:0] CMD_EVALUATE = 2'd2;

   // Minimum scroll length register.
   localparam int unsigned LEN_BITS = 12;
   localparam logic [LEN_BITS-1:0] MIN_LEN_RESET = 12'd32;

   // Point count saturates here: three or more points.
   localparam logic [1:0] COUNT_FULL = 2'd3;

   typedef logic [1:0] cmd_type;

endpackage

[hw/rtl/touch_scroll_gesture_detector_unit.sv]
`timescale 1ns / 1ps
// An evaluate transaction shows its result on rsp_ in the cycle after the edge that accepts it;
// point transactions update the finger tracks at their accepting edge.
// Throughput: one request transaction per cycle while the result side keeps rsp_tready high.
// Reset (synchronous, active high) clears both tracks and any pending result, and loads the
// minimum scroll length with 32.
`include "assert_macros.svh"

module touch_scroll_gesture_detector_unit
   import tsgd_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12,
   localparam int unsigned REQ_W = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_W = ((4 + 4 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_tvalid,
   output logic                req_tready,
   // req_tdata from bit 0: pos_x, pos_y, zero padding
   input  logic [REQ_W-1:0]    req_tdata,
   // req_tuser: cmd
   input  logic [1:0]          req_tuser,

   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // rsp_tdata from bit 0: one_found, one_down, one_x, one_y,
   // two_found, two_down, two_x, two_y, zero padding
   output logic [RSP_W-1:0]    rsp_tdata,

   input  logic                csr_wr_en,
   input  logic [LEN_BITS-1:0] csr_wr_data
);

   // Comparisons of travel against the length register need the wider of the two widths.
   localparam int unsigned CMP_W = (COORD_BITS > LEN_BITS) ? COORD_BITS : LEN_BITS;
   localparam int unsigned FIELDS_W = 4 + 4 * COORD_BITS;

   // Absolute difference of two unsigned coordinates; it always fits the coordinate width.
   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   cmd_type               cmd;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   logic                  req_fire;
   logic                  eval_fire;

   assign cmd       = req_tuser;
   assign pos_x     = req_tdata[COORD_BITS-1:0];
   assign pos_y     = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign req_fire  = req_tvalid && req_tready;
   assign eval_fire = req_fire && (cmd == CMD_EVALUATE);

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [LEN_BITS-1:0] min_len_ff, min_len_in;

   assign min_len_in = csr_wr_en ? csr_wr_data : min_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MIN_LEN_RESET;
      end else begin
         min_len_ff <= min_len_in;
      end
   end

   // ------------------------------------------------------------------
   // Finger tracks. Index 0 is finger one, index 1 finger two; each
   // generate instance only touches its own entries.
   // ------------------------------------------------------------------
   logic [COORD_BITS-1:0] first_x_ff [2];
   logic [COORD_BITS-1:0] first_y_ff [2];
   logic [COORD_BITS-1:0] prev_x_ff  [2];
   logic [COORD_BITS-1:0] prev_y_ff  [2];
   logic [COORD_BITS-1:0] first_x_in [2];
   logic [COORD_BITS-1:0] first_y_in [2];
   logic [COORD_BITS-1:0] prev_x_in  [2];
   logic [COORD_BITS-1:0] prev_y_in  [2];
   logic [1:0]            count_ff   [2];
   logic [1:0]            count_in   [2];
   logic                  side_ff    [2];
   logic                  side_in    [2];
   logic                  up_ff      [2];
   logic                  up_in      [2];
   logic                  down_ff    [2];
   logic                  down_in    [2];

   // Per finger verdict at evaluate time.
   logic                  scrolls [2];
   logic                  heads_down [2];

   for (genvar f = 0; f < 2; f++) begin : g_finger
      localparam cmd_type FINGER_CMD = (f == 0) ? CMD_ADD_ONE : CMD_ADD_TWO;

      logic                  add;
      logic [COORD_BITS-1:0] seg_dx;
      logic [COORD_BITS-1:0] seg_dy;
      logic [COORD_BITS+1:0] seg_dx2;
      logic [COORD_BITS+1:0] seg_dy3;
      logic                  seg_side;
      logic [COORD_BITS-1:0] tot_dx;
      logic [COORD_BITS-1:0] tot_dy;
      logic [COORD_BITS+1:0] tot_dx3;
      logic                  tot_down;
      logic                  long_enough;

      assign add = req_fire && (cmd == FINGER_CMD);

      // A segment is too sideways when 2|dx| > 3|dy|.
      assign seg_dx   = abs_diff(pos_x, prev_x_ff[f]);
      assign seg_dy   = abs_diff(pos_y, prev_y_ff[f]);
      assign seg_dx2  = {1'b0, seg_dx, 1'b0};
      assign seg_dy3  = {1'b0, seg_dy, 1'b0} + {2'b00, seg_dy};
      assign seg_side = seg_dx2 > seg_dy3;

      always_comb begin
         first_x_in[f] = first_x_ff[f];
         first_y_in[f] = first_y_ff[f];
         prev_x_in[f]  = prev_x_ff[f];
         prev_y_in[f]  = prev_y_ff[f];
         count_in[f]   = count_ff[f];
         side_in[f]    = side_ff[f];
         up_in[f]      = up_ff[f];
         down_in[f]    = down_ff[f];
         if (eval_fire) begin
            count_in[f] = 2'd0;
            side_in[f]  = 1'b0;
            up_in[f]    = 1'b0;
            down_in[f]  = 1'b0;
         end else if (add) begin
            prev_x_in[f] = pos_x;
            prev_y_in[f] = pos_y;
            if (count_ff[f] == 2'd0) begin
               first_x_in[f] = pos_x;
               first_y_in[f] = pos_y;
            end else begin
               side_in[f] = side_ff[f] | seg_side;
               up_in[f]   = up_ff[f]   | (pos_y < prev_y_ff[f]);
               down_in[f] = down_ff[f] | (pos_y > prev_y_ff[f]);
            end
            if (count_ff[f] != COUNT_FULL) begin
               count_in[f] = count_ff[f] + 2'd1;
            end
         end
      end

      // Point registers only matter once the count says they were written.
      always_ff @(posedge clock) begin
         first_x_ff[f] <= first_x_in[f];
         first_y_ff[f] <= first_y_in[f];
         prev_x_ff[f]  <= prev_x_in[f];
         prev_y_ff[f]  <= prev_y_in[f];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            count_ff[f] <= 2'd0;
            side_ff[f]  <= 1'b0;
            up_ff[f]    <= 1'b0;
            down_ff[f]  <= 1'b0;
         end else begin
            count_ff[f] <= count_in[f];
            side_ff[f]  <= side_in[f];
            up_ff[f]    <= up_in[f];
            down_ff[f]  <= down_in[f];
         end
      end

      // Whole-track test: enough points, enough vertical travel, steep
      // enough overall, no sideways segment and no segment running back.
      assign tot_dx      = abs_diff(prev_x_ff[f], first_x_ff[f]);
      assign tot_dy      = abs_diff(prev_y_ff[f], first_y_ff[f]);
      assign tot_dx3     = {1'b0, tot_dx, 1'b0} + {2'b00, tot_dx};
      assign tot_down    = prev_y_ff[f] > first_y_ff[f];
      assign long_enough = CMP_W'(tot_dy) >= CMP_W'(min_len_ff);

      assign scrolls[f] = (count_ff[f] == COUNT_FULL) && long_enough &&
                          (tot_dx3 <= {2'b00, tot_dy}) && !side_ff[f] &&
                          (tot_down ? !up_ff[f] : !down_ff[f]);
      assign heads_down[f] = tot_down;
   end

   // ------------------------------------------------------------------
   // Result fields. Fields with no meaning are forced to zero.
   // ------------------------------------------------------------------
   logic                  one_found;
   logic                  one_down;
   logic [COORD_BITS-1:0] one_x;
   logic [COORD_BITS-1:0] one_y;
   logic                  two_found;
   logic                  two_down;
   logic [COORD_BITS-1:0] two_x;
   logic [COORD_BITS-1:0] two_y;
   logic [COORD_BITS:0]   sum_x;
   logic [COORD_BITS:0]   sum_y;
   logic [FIELDS_W-1:0]   fields;

   assign one_found = scrolls[0];
   assign one_down  = scrolls[0] && heads_down[0];
   assign one_x     = scrolls[0] ? prev_x_ff[0] : '0;
   assign one_y     = scrolls[0] ? prev_y_ff[0] : '0;

   // Mean of the two last points, rounded down: drop the low bit of the sum.
   assign sum_x     = {1'b0, prev_x_ff[0]} + {1'b0, prev_x_ff[1]};
   assign sum_y     = {1'b0, prev_y_ff[0]} + {1'b0, prev_y_ff[1]};
   assign two_found = scrolls[0] && scrolls[1] && (heads_down[0] == heads_down[1]);
   assign two_down  = two_found && heads_down[0];
   assign two_x     = two_found ? sum_x[COORD_BITS:1] : '0;
   assign two_y     = two_found ? sum_y[COORD_BITS:1] : '0;

   assign fields = {two_y, two_x, two_down, two_found, one_y, one_x, one_down, one_found};

   // ------------------------------------------------------------------
   // Output register. A new request is taken whenever the held result is
   // free or is being taken in the same cycle.
   // ------------------------------------------------------------------
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eval_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'(fields);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `ASSERT_CLK(a_eval_gives_result, clock, reset, eval_fire |=> rsp_valid_ff, "evaluate lost its result")
   `ASSERT_CLK(a_eval_clears, clock, reset, eval_fire |=> (count_ff[0] == 2'd0 && count_ff[1] == 2'd0), "tracks not cleared after evaluate")
   `ASSERT_CLK(a_count_saturates, clock, reset, (count_ff[0] == COUNT_FULL && !eval_fire) |=> count_ff[0] == COUNT_FULL, "finger one count left saturation without evaluate")
   `ASSERT_NEVER(a_two_needs_one, clock, reset, two_found && !one_found, "two-finger scroll without finger one scrolling")

endmodule
